/* rtl/s2dconv_pkg.sv */
// Shared types, constants and helper functions for the strided RGB convolution block.
package s2dconv_pkg;

  localparam int S2D_QDEPTH   = 4;
  localparam int KSIZE        = 5;
  localparam int TAPS         = KSIZE * KSIZE;
  localparam int IMG_MAX      = 64;

  // Configuration register indexes
  localparam logic [2:0] CFG_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_STRIDE = 3'd2;
  localparam logic [2:0] CFG_BORDER = 3'd3;
  localparam logic [2:0] CFG_SCALE  = 3'd4;
  localparam logic [2:0] CFG_OFFSET = 3'd5;

  // Input item kinds
  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_COEF  = 2'd1;
  localparam logic [1:0] KIND_CONV  = 2'd2;

  typedef enum logic [1:0] {
    BM_CLAMP  = 2'd0,
    BM_WRAP   = 2'd1,
    BM_MIRROR = 2'd2,
    BM_ZERO   = 2'd3
  } border_t;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_COEF  = 2'd1,
    OP_CONV  = 2'd2
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [5:0]         col;
    logic [5:0]         row;
    logic [4:0]         coef_index;
    logic signed [15:0] coef_value;
    logic [23:0]        rgb;
  } cmd_t;

  typedef struct packed {
    logic [6:0]         width;
    logic [6:0]         height;
    logic [3:0]         stride;
    border_t            mode;
    logic signed [15:0] scale;
    logic signed [15:0] offset;
  } cfg_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] idx;
  } map_t;

  // Clamp a configured size to 1..IMG_MAX
  function automatic logic [6:0] eff_size(logic [6:0] v);
    logic [6:0] r;
    r = v;
    if (v == 7'd0) r = 7'd1;
    else if (v > 7'(IMG_MAX)) r = 7'(IMG_MAX);
    return r;
  endfunction

  // Step a residue modulo md by one
  function automatic logic [6:0] mod_inc(logic [6:0] m, logic [6:0] md);
    logic [6:0] n;
    n = m + 7'd1;
    return (n == md) ? 7'd0 : n;
  endfunction

  // Move a residue two steps back, modulo md
  function automatic logic [6:0] mod_back2(logic [6:0] r, logic [6:0] md);
    logic signed [8:0] t;
    t = $signed({2'b00, r}) - 9'sd2;
    if (t < 0) t = t + $signed({2'b00, md});
    if (t < 0) t = t + $signed({2'b00, md});
    return t[6:0];
  endfunction

  // Map a raw source coordinate into the image per border mode
  function automatic map_t map_coord(logic signed [10:0] c, logic [6:0] m,
                                     logic [6:0] sz, logic [6:0] md, border_t mode);
    map_t r;
    logic signed [10:0] csz;
    csz = $signed({4'b0000, sz});
    r.ok = 1'b1;
    r.idx = c[5:0];
    if (!(c >= 0 && c < csz)) begin
      case (mode)
        BM_WRAP:   r.idx = m[5:0];
        BM_MIRROR: begin
          if (m >= sz) r.idx = 6'(md - m);
          else r.idx = m[5:0];
        end
        BM_ZERO:   r.ok = 1'b0;
        default:   r.idx = (c < 0) ? 6'd0 : 6'(sz - 7'd1);
      endcase
    end
    return r;
  endfunction

endpackage

/* rtl/s2dconv_front.sv */
// Front end: accepts input items, classifies them and drops ones with no effect.
module s2dconv_front import s2dconv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic [5:0]         in_col,
  input  logic [5:0]         in_row,
  input  logic [4:0]         in_coef_index,
  input  logic signed [15:0] in_coef_value,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  input  logic               q_full,
  output logic               q_push,
  output cmd_t               q_cmd
);

  logic keep;
  logic cnt_r;
  logic cnt_nxt;

  assign in_ready = !q_full;

  always_comb begin
    q_cmd.col        = in_col;
    q_cmd.row        = in_row;
    q_cmd.coef_index = in_coef_index;
    q_cmd.coef_value = in_coef_value;
    q_cmd.rgb        = {in_red, in_green, in_blue};
    q_cmd.op         = OP_CONV;
    keep             = 1'b0;
    case (in_kind)
      KIND_PIXEL: begin
        q_cmd.op = OP_PIXEL;
        keep = 1'b1;
      end
      KIND_COEF: begin
        q_cmd.op = OP_COEF;
        keep = (in_coef_index < 5'(TAPS));
      end
      KIND_CONV: begin
        q_cmd.op = OP_CONV;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign q_push = in_valid && in_ready && keep;

  // Toggle on every dropped transfer; kept for debug visibility of discarded items
  assign cnt_nxt = cnt_r ^ (in_valid && in_ready && !keep);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/s2dconv_queue.sv */
// Command queue between the front end and the compute engine.
module s2dconv_queue import s2dconv_pkg::*; #(
  parameter int DEPTH = S2D_QDEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          buf_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = buf_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
    end
    if (push && !pop) cnt_nxt = cnt_r + CW'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= push_cmd;
  end

endmodule

/* rtl/s2dconv_back.sv */
// Compute engine: frame memory, coefficients, border mapping, MAC and output scaling.
module s2dconv_back import s2dconv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               cmd_valid,
  input  cmd_t               cmd,
  output logic               cmd_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_red,
  output logic signed [15:0] out_green,
  output logic signed [15:0] out_blue,
  output logic               out_saturated
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MOD   = 6'b000010,
    ST_TAP   = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_FIN   = 6'b010000,
    ST_WAIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [23:0]        mem [IMG_MAX*IMG_MAX];
  logic [23:0]        rd_r;
  logic signed [15:0] coef_r [TAPS];

  logic [6:0] wsz, hsz, wmd, hmd;

  logic [9:0]  cx_r, cy_r, divx_r, divy_r;
  logic [6:0]  remx_r, remy_r, remx_nxt, remy_nxt;
  logic [7:0]  shx, shy;
  logic [3:0]  dcnt_r;

  logic signed [10:0] rx_r, ry_r;
  logic [6:0]  mx_r, mx0_r, my_r;
  logic [2:0]  tj_r;
  logic [4:0]  k_r;
  map_t        mapx, mapy;

  logic               a1_r, a2_r;
  logic signed [15:0] c1_r;
  logic signed [24:0] pr_r [3];
  logic signed [29:0] acc_r [3];

  logic [1:0]         fcnt_r, pch_r;
  logic               pv_r;
  logic signed [45:0] prod_r;
  logic signed [45:0] rnd;
  logic signed [26:0] v27;
  logic signed [15:0] sat_val;
  logic               sat_hit;
  logic signed [15:0] res_r [3];
  logic               sat_r;

  assign wsz = eff_size(cfg.width);
  assign hsz = eff_size(cfg.height);
  assign wmd = (cfg.mode == BM_MIRROR) ? ((wsz == 7'd1) ? 7'd1 : 7'((wsz - 7'd1) << 1)) : wsz;
  assign hmd = (cfg.mode == BM_MIRROR) ? ((hsz == 7'd1) ? 7'd1 : 7'((hsz - 7'd1) << 1)) : hsz;

  assign cmd_pop = (state_r == ST_IDLE) && cmd_valid;

  // Restoring remainder step for both axes
  assign shx = {remx_r, divx_r[9]};
  assign shy = {remy_r, divy_r[9]};
  assign remx_nxt = (shx >= {1'b0, wmd}) ? 7'(shx - {1'b0, wmd}) : shx[6:0];
  assign remy_nxt = (shy >= {1'b0, hmd}) ? 7'(shy - {1'b0, hmd}) : shy[6:0];

  assign mapx = map_coord(rx_r, mx_r, wsz, wmd, cfg.mode);
  assign mapy = map_coord(ry_r, my_r, hsz, hmd, cfg.mode);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (cmd_valid && cmd.op == OP_CONV) state_nxt = ST_MOD;
      ST_MOD:   if (dcnt_r == 4'd9) state_nxt = ST_TAP;
      ST_TAP:   if (k_r == 5'(TAPS - 1)) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!a1_r && !a2_r) state_nxt = ST_FIN;
      ST_FIN:   if (fcnt_r == 2'd3) state_nxt = ST_WAIT;
      ST_WAIT:  if (!out_valid || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      a1_r      <= 1'b0;
      a2_r      <= 1'b0;
      pv_r      <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < TAPS; i++) coef_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      a1_r    <= (state_r == ST_TAP);
      a2_r    <= a1_r;
      pv_r    <= (state_r == ST_FIN) && (fcnt_r != 2'd3);
      if (cmd_pop && cmd.op == OP_COEF) coef_r[cmd.coef_index] <= cmd.coef_value;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state_r == ST_WAIT && (!out_valid || out_ready)) out_valid <= 1'b1;
    end
  end

  // Frame memory: one port, write on pixel commands, read during the tap sweep
  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.op == OP_PIXEL) begin
      mem[{cmd.row, cmd.col}] <= cmd.rgb;
    end else if (state_r == ST_TAP) begin
      // Zero-border taps read as black
      rd_r <= (mapx.ok && mapy.ok) ? mem[{mapy.idx, mapx.idx}] : 24'd0;
    end
  end

  // Remainder and tap sequencing
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        cx_r   <= 10'(cmd.col) * 10'(cfg.stride);
        cy_r   <= 10'(cmd.row) * 10'(cfg.stride);
        divx_r <= 10'(cmd.col) * 10'(cfg.stride);
        divy_r <= 10'(cmd.row) * 10'(cfg.stride);
        remx_r <= '0;
        remy_r <= '0;
        dcnt_r <= '0;
      end
      ST_MOD: begin
        divx_r <= divx_r << 1;
        divy_r <= divy_r << 1;
        remx_r <= remx_nxt;
        remy_r <= remy_nxt;
        dcnt_r <= dcnt_r + 4'd1;
        mx_r   <= mod_back2(remx_nxt, wmd);
        mx0_r  <= mod_back2(remx_nxt, wmd);
        my_r   <= mod_back2(remy_nxt, hmd);
        rx_r   <= $signed({1'b0, cx_r}) - 11'sd2;
        ry_r   <= $signed({1'b0, cy_r}) - 11'sd2;
        tj_r   <= '0;
        k_r    <= '0;
      end
      ST_TAP: begin
        c1_r <= (mapx.ok && mapy.ok) ? coef_r[k_r] : 16'sd0;
        k_r  <= k_r + 5'd1;
        if (tj_r == 3'(KSIZE - 1)) begin
          tj_r <= '0;
          rx_r <= $signed({1'b0, cx_r}) - 11'sd2;
          mx_r <= mx0_r;
          ry_r <= ry_r + 11'sd1;
          my_r <= mod_inc(my_r, hmd);
        end else begin
          tj_r <= tj_r + 3'd1;
          rx_r <= rx_r + 11'sd1;
          mx_r <= mod_inc(mx_r, wmd);
        end
      end
      default: ;
    endcase
  end

  // Multiply-accumulate pipeline
  always_ff @(posedge clk) begin
    pr_r[0] <= c1_r * $signed({1'b0, rd_r[23:16]});
    pr_r[1] <= c1_r * $signed({1'b0, rd_r[15:8]});
    pr_r[2] <= c1_r * $signed({1'b0, rd_r[7:0]});
    if (state_r == ST_MOD) begin
      for (int i = 0; i < 3; i++) acc_r[i] <= '0;
    end else if (a2_r) begin
      for (int i = 0; i < 3; i++) acc_r[i] <= acc_r[i] + 30'(pr_r[i]);
    end
  end

  // Scale, round half up, offset and saturate, one channel per cycle
  assign rnd = prod_r + 46'sd524288;
  assign v27 = $signed({rnd[45], rnd[45:20]}) + 27'(cfg.offset);

  always_comb begin
    sat_hit = 1'b0;
    sat_val = v27[15:0];
    if (v27 > 27'sd32767) begin
      sat_hit = 1'b1;
      sat_val = 16'sh7fff;
    end else if (v27 < -27'sd32768) begin
      sat_hit = 1'b1;
      sat_val = 16'sh8000;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MOD) begin
      fcnt_r <= '0;
      sat_r  <= 1'b0;
    end else if (state_r == ST_FIN) begin
      fcnt_r <= fcnt_r + 2'd1;
      if (fcnt_r != 2'd3) begin
        prod_r <= acc_r[fcnt_r] * cfg.scale;
        pch_r  <= fcnt_r;
      end
    end
    if (pv_r) begin
      res_r[pch_r] <= sat_val;
      if (sat_hit) sat_r <= 1'b1;
    end
    if (state_r == ST_WAIT && (!out_valid || out_ready)) begin
      out_red       <= res_r[0];
      out_green     <= res_r[1];
      out_blue      <= res_r[2];
      out_saturated <= sat_r;
    end
  end

endmodule

/* rtl/strided_2d_convolution_rgb.sv */
// Top level of the strided 5x5 RGB convolution block.
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_ready    kind, col, row, coef_index, coef_value, rgb
//  out_     output     out_valid / out_ready  red, green, blue, saturated
//  cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
// Pixel and coefficient writes are applied in the engine as they are popped. A compute
// request is popped, then runs 10 remainder steps, 25 frame memory reads on its
// single port, the pipeline drain, the scaling of each channel and one hand-off to the
// output register. Reset is synchronous and clears control and configuration; the
// frame memory is not cleared. The queue lets input transfers continue while the
// engine or a waiting result holds.
module strided_2d_convolution_rgb import s2dconv_pkg::*; #(
  parameter int QUEUE_DEPTH = S2D_QDEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic [5:0]         in_col,
  input  logic [5:0]         in_row,
  input  logic [4:0]         in_coef_index,
  input  logic signed [15:0] in_coef_value,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_red,
  output logic signed [15:0] out_green,
  output logic signed [15:0] out_blue,
  output logic               out_saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  cfg_t cfg_r;
  logic q_full, q_push, q_valid, q_pop;
  cmd_t q_cmd, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= 7'd64;
      cfg_r.height <= 7'd64;
      cfg_r.stride <= 4'd1;
      cfg_r.mode   <= BM_CLAMP;
      cfg_r.scale  <= 16'sd256;
      cfg_r.offset <= 16'sd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WIDTH:  cfg_r.width  <= cfg_data[6:0];
        CFG_HEIGHT: cfg_r.height <= cfg_data[6:0];
        CFG_STRIDE: cfg_r.stride <= cfg_data[3:0];
        CFG_BORDER: cfg_r.mode   <= border_t'(cfg_data[1:0]);
        CFG_SCALE:  cfg_r.scale  <= cfg_data;
        CFG_OFFSET: cfg_r.offset <= cfg_data;
        default: ;
      endcase
    end
  end

  s2dconv_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_col        (in_col),
    .in_row        (in_row),
    .in_coef_index (in_coef_index),
    .in_coef_value (in_coef_value),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_cmd)
  );

  s2dconv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  s2dconv_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .cmd_valid     (q_valid),
    .cmd           (q_head),
    .cmd_pop       (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_saturated (out_saturated)
  );

endmodule

/* dv/tb_strided_2d_convolution_rgb.sv */
`timescale 1ns / 1ps
// Self-checking randomized testbench for the strided 5x5 RGB convolution block.
import s2dconv_pkg::*;

typedef struct {
  logic signed [15:0] red;
  logic signed [15:0] green;
  logic signed [15:0] blue;
  logic               sat;
} conv_px_t;

class conv_scoreboard;
  logic [23:0]        frame [IMG_MAX*IMG_MAX];
  bit                 written [IMG_MAX*IMG_MAX];
  logic signed [15:0] coefs [TAPS];
  logic [6:0]         width_r;
  logic [6:0]         height_r;
  logic [3:0]         stride_r;
  border_t            mode_r;
  logic signed [15:0] scale_r;
  logic signed [15:0] offset_r;
  conv_px_t           pending [$];
  int                 errors;

  function new();
    foreach (coefs[i]) coefs[i] = '0;
    foreach (written[i]) written[i] = 1'b0;
    width_r  = 7'd64;
    height_r = 7'd64;
    stride_r = 4'd1;
    mode_r   = BM_CLAMP;
    scale_r  = 16'sd256;
    offset_r = 16'sd0;
    errors   = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [15:0] d);
    case (idx)
      CFG_WIDTH:  width_r  = d[6:0];
      CFG_HEIGHT: height_r = d[6:0];
      CFG_STRIDE: stride_r = d[3:0];
      CFG_BORDER: mode_r   = border_t'(d[1:0]);
      CFG_SCALE:  scale_r  = d;
      CFG_OFFSET: offset_r = d;
      default: ;
    endcase
  endfunction

  function int eff(logic [6:0] v);
    if (v == 0) return 1;
    if (v > IMG_MAX) return IMG_MAX;
    return int'(v);
  endfunction

  function int pmod(int a, int m);
    int r;
    r = a % m;
    return (r < 0) ? r + m : r;
  endfunction

  // -1 means the tap reads the constant zero border
  function int fold(int c, int sz);
    int p;
    int m;
    if (c >= 0 && c < sz) return c;
    case (mode_r)
      BM_WRAP: return pmod(c, sz);
      BM_MIRROR: begin
        if (sz == 1) return 0;
        p = 2 * (sz - 1);
        m = pmod(c, p);
        return (m >= sz) ? p - m : m;
      end
      BM_ZERO: return -1;
      default: return (c < 0) ? 0 : sz - 1;
    endcase
  endfunction

  function int tap_addr(int col, int row, int t);
    int sx;
    int sy;
    sy = fold(row * int'(stride_r) + t / KSIZE - KSIZE / 2, eff(height_r));
    sx = fold(col * int'(stride_r) + t % KSIZE - KSIZE / 2, eff(width_r));
    if (sx < 0 || sy < 0) return -1;
    return sy * IMG_MAX + sx;
  endfunction

  // Address of the first never-written pixel that a request would read, or -1
  function int missing_pixel(int col, int row);
    int a;
    for (int t = 0; t < TAPS; t++) begin
      a = tap_addr(col, row, t);
      if (a >= 0 && !written[a]) return a;
    end
    return -1;
  endfunction

  function logic signed [15:0] finish_ch(longint acc, inout logic sat);
    longint v;
    v = ((acc * longint'(scale_r) + (longint'(1) << 19)) >>> 20) + longint'(offset_r);
    if (v > 32767) begin
      sat = 1'b1;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function void note_input(logic [1:0] kind, logic [5:0] col, logic [5:0] row,
                           logic [4:0] ci, logic signed [15:0] cv, logic [23:0] rgb);
    longint   acc_r;
    longint   acc_g;
    longint   acc_b;
    int       a;
    logic [23:0] p;
    conv_px_t e;
    acc_r = 0;
    acc_g = 0;
    acc_b = 0;
    case (kind)
      KIND_PIXEL: begin
        frame[{row, col}]   = rgb;
        written[{row, col}] = 1'b1;
      end
      KIND_COEF: if (ci < TAPS) coefs[ci] = cv;
      KIND_CONV: begin
        for (int t = 0; t < TAPS; t++) begin
          a = tap_addr(int'(col), int'(row), t);
          if (a >= 0) begin
            p = frame[a];
            acc_r += longint'(coefs[t]) * longint'(p[23:16]);
            acc_g += longint'(coefs[t]) * longint'(p[15:8]);
            acc_b += longint'(coefs[t]) * longint'(p[7:0]);
          end
        end
        e.sat   = 1'b0;
        e.red   = finish_ch(acc_r, e.sat);
        e.green = finish_ch(acc_g, e.sat);
        e.blue  = finish_ch(acc_b, e.sat);
        pending.push_back(e);
      end
      default: ;
    endcase
  endfunction

  function void check_result(logic signed [15:0] r, logic signed [15:0] g,
                             logic signed [15:0] b, logic s);
    conv_px_t e;
    if (pending.size() == 0) begin
      $error("unexpected result red=%0d green=%0d blue=%0d", r, g, b);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (r !== e.red) begin
      $error("red_out expected %0d actual %0d", e.red, r);
      errors++;
    end
    if (g !== e.green) begin
      $error("green_out expected %0d actual %0d", e.green, g);
      errors++;
    end
    if (b !== e.blue) begin
      $error("blue_out expected %0d actual %0d", e.blue, b);
      errors++;
    end
    if (s !== e.sat) begin
      $error("saturated expected %0b actual %0b", e.sat, s);
      errors++;
    end
  endfunction
endclass

module tb_strided_2d_convolution_rgb;
  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE      = 60;
  localparam int HOLD_LEN    = 400;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 172;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_kind = '0;
  logic [5:0]         in_col = '0;
  logic [5:0]         in_row = '0;
  logic [4:0]         in_coef_index = '0;
  logic signed [15:0] in_coef_value = '0;
  logic [7:0]         in_red = '0;
  logic [7:0]         in_green = '0;
  logic [7:0]         in_blue = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_red;
  logic signed [15:0] out_green;
  logic signed [15:0] out_blue;
  logic               out_saturated;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  conv_scoreboard sb = new();
  int send_gap_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  int quiet = 0;

  strided_2d_convolution_rgb u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt - 1;
    end else if (hold_asked != hold_seen) begin
      hold_seen <= hold_asked;
      hold_cnt  <= HOLD_LEN;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_red, out_green, out_blue, out_saturated);
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == QUIET_LIMIT) begin
      $display("tb_strided_2d_convolution_rgb failed");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] kind, logic [5:0] col, logic [5:0] row,
                           logic [4:0] ci, logic [15:0] cv, logic [23:0] rgb);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_col        <= col;
    in_row        <= row;
    in_coef_index <= ci;
    in_coef_value <= cv;
    {in_red, in_green, in_blue} <= rgb;
    do @(posedge clk); while (!in_ready);
    sb.note_input(kind, col, row, ci, cv, rgb);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, d);
  endtask

  // Wait for every outstanding result, then for any write still in flight
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_regs(logic [6:0] w, logic [6:0] h, logic [3:0] st, border_t bm,
                              logic [15:0] sc, logic [15:0] ofs);
    logic [15:0] junk;
    junk = 16'($urandom);
    // Upper data bits are ignored by the block; toggle them anyway
    write_reg(CFG_WIDTH,  {junk[15:7], w});
    write_reg(CFG_HEIGHT, {junk[8:0], h});
    write_reg(CFG_STRIDE, {junk[11:0], st});
    write_reg(CFG_BORDER, {junk[13:0], bm});
    write_reg(CFG_SCALE,  sc);
    write_reg(CFG_OFFSET, ofs);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item();
    int r;
    int col;
    int row;
    int miss;
    logic [15:0] cv;
    r = $urandom_range(99);
    if (r < 50) begin
      col = ($urandom_range(1)) ? $urandom_range(63) : $urandom_range(7);
      row = ($urandom_range(1)) ? $urandom_range(63) : $urandom_range(7);
      miss = sb.missing_pixel(col, row);
      if (miss < 0)
        send_item(KIND_CONV, 6'(col), 6'(row), 5'($urandom), 16'($urandom), 24'($urandom));
      else
        // fill the hole so later requests can reach it
        send_item(KIND_PIXEL, 6'(miss % IMG_MAX), 6'(miss / IMG_MAX), 5'($urandom),
                  16'($urandom), 24'($urandom));
    end else if (r < 72) begin
      col = ($urandom_range(4) == 0) ? $urandom_range(63) : $urandom_range(sb.eff(sb.width_r) - 1);
      row = ($urandom_range(4) == 0) ? $urandom_range(63) : $urandom_range(sb.eff(sb.height_r) - 1);
      send_item(KIND_PIXEL, 6'(col), 6'(row), 5'($urandom), 16'($urandom), 24'($urandom));
    end else if (r < 92) begin
      case ($urandom_range(3))
        0: cv = ($urandom_range(1)) ? 16'h7fff : 16'h8000;
        1: cv = 16'($signed($urandom_range(0, 8192)) - 4096);
        default: cv = 16'($urandom);
      endcase
      send_item(KIND_COEF, 6'($urandom), 6'($urandom), 5'($urandom_range(TAPS - 1)),
                cv, 24'($urandom));
    end else if (r < 96) begin
      send_item(2'd3, 6'($urandom), 6'($urandom), 5'($urandom), 16'($urandom), 24'($urandom));
    end else begin
      send_item(KIND_COEF, 6'($urandom), 6'($urandom), 5'($urandom_range(TAPS, 31)),
                16'($urandom), 24'($urandom));
    end
  endtask

  initial begin
    logic [6:0]  pw [PHASES] = '{7'd8, 7'd1, 7'd64, 7'd5, 7'd0, 7'd16, 7'd64, 7'd3};
    logic [6:0]  ph [PHASES] = '{7'd8, 7'd1, 7'd64, 7'd3, 7'd100, 7'd12, 7'd2, 7'd64};
    logic [3:0]  ps [PHASES] = '{4'd1, 4'd0, 4'd8, 4'd3, 4'd2, 4'd15, 4'd1, 4'd4};
    border_t     pm [PHASES] = '{BM_CLAMP, BM_MIRROR, BM_WRAP, BM_MIRROR,
                                 BM_ZERO, BM_CLAMP, BM_WRAP, BM_MIRROR};
    logic [15:0] psc [PHASES] = '{16'd256, 16'h8000, 16'h7fff, 16'd384,
                                  16'hff00, 16'd1, 16'hffff, 16'd512};
    logic [15:0] pof [PHASES] = '{16'd0, 16'h7fff, 16'h8000, 16'hff9c,
                                  16'd50, 16'hffff, 16'd0, 16'd1000};

    send_gap_pct = 20;
    stall_pct    = 53;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: coefficient extremes, ignored items, top-left corner, far corner
    send_item(KIND_COEF, 6'd0, 6'd0, 5'd0, 16'h7fff, 24'h0);
    send_item(KIND_COEF, 6'd0, 6'd0, 5'd24, 16'h8000, 24'h0);
    send_item(KIND_COEF, 6'd0, 6'd0, 5'd12, 16'h1000, 24'h0);
    send_item(KIND_COEF, 6'd0, 6'd0, 5'd31, 16'h1234, 24'h0);
    send_item(KIND_COEF, 6'd0, 6'd0, 5'd25, 16'hffff, 24'h0);
    send_item(2'd3, 6'd63, 6'd63, 5'd31, 16'hffff, 24'hffffff);
    for (int i = 0; i < 9; i++)
      send_item(KIND_PIXEL, 6'(i % 3), 6'(i / 3), 5'd0, 16'h0,
                (i == 0) ? 24'hffffff : (i == 1) ? 24'h000000 : 24'($urandom));
    send_item(KIND_PIXEL, 6'd63, 6'd63, 5'd0, 16'h0, 24'hffffff);
    send_item(KIND_CONV, 6'd0, 6'd0, 5'd0, 16'h0, 24'h0);
    send_item(KIND_COEF, 6'd0, 6'd0, 5'd6, 16'hf000, 24'h0);
    send_item(KIND_CONV, 6'd1, 6'd1, 5'd0, 16'h0, 24'h0);
    send_item(KIND_CONV, 6'd0, 6'd0, 5'd0, 16'h0, 24'h0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      program_regs(pw[p], ph[p], ps[p], pm[p], psc[p], pof[p]);
      if (p == 3) begin
        send_gap_pct = 53;
        stall_pct    = 20;
      end else if (p == 6) begin
        send_gap_pct = 0;
        stall_pct    = 0;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2 && (p == 1 || p == 6)) hold_asked <= hold_asked + 1;
        random_item();
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_strided_2d_convolution_rgb passed");
    else
      $display("tb_strided_2d_convolution_rgb failed");
    $finish;
  end
endmodule

/* strided_2d_convolution_rgb.f */
rtl/s2dconv_pkg.sv
rtl/s2dconv_front.sv
rtl/s2dconv_queue.sv
rtl/s2dconv_back.sv
rtl/strided_2d_convolution_rgb.sv
dv/tb_strided_2d_convolution_rgb.sv
